@@ hw/rtl/cgaplt_pkg.sv @@
package cgaplt_pkg;

    localparam int FRAME_BYTES_DEF = 16384;

    // screen geometry of the interlaced 320x200 four-color mode
    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 200;
    localparam int LINE_BYTES = 80;
    localparam int PIX_ADDR_W = 14;
    localparam logic [PIX_ADDR_W-1:0] ODD_BANK = 14'h2000;

    localparam int IDX_W = 12;
    localparam int BPR_W = 7;

    typedef enum logic [1:0] {
        CMD_PLOT   = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SPRITE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t          command;
        logic [8:0]         x;
        logic [7:0]         y;
        logic [8:0]         width;
        logic [7:0]         height;
        logic [1:0]         color;
        logic [7:0]         pixel_byte;
        logic [IDX_W-1:0]   byte_index;
        logic [BPR_W-1:0]   bytes_per_row;
        logic [PIX_ADDR_W-1:0] read_address;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV_WAIT,
        ST_PIX_READ,
        ST_PIX_WRITE,
        ST_ADDR_READ,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic clear_write;
        logic div_start;
        logic sprite_base;
        logic pixel_read;
        logic pixel_write;
        logic pixel_skip;
        logic addr_read;
        logic clip_set;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t command;
        logic      clear_last;
        logic      fill_empty;
        logic      sprite_reject;
        logic      div_done;
        logic      on_screen;
        logic      pixel_last;
        logic      out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/cgaplt_stream_if.sv @@
interface cgaplt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/cgaplt_divider.sv @@
module cgaplt_divider
    import cgaplt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [BPR_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] quotient,
    output logic [BPR_W-1:0] remainder
);

    localparam int CNT_W = $clog2(IDX_W);

    logic [IDX_W-1:0] quo_reg, quo_next;
    logic [BPR_W-1:0] rem_reg, rem_next;
    logic [BPR_W-1:0] dvs_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BPR_W:0]   trial;
    logic [BPR_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial      = {rem_reg, quo_reg[IDX_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        fits       = trial >= {1'b0, dvs_reg};
        rem_next   = fits ? diff[BPR_W-1:0] : trial[BPR_W-1:0];
        quo_next   = {quo_reg[IDX_W-2:0], fits};
        count_next = count_reg + CNT_W'(1);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg && count_reg == CNT_W'(IDX_W - 1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/cgaplt_ctrl.sv @@
module cgaplt_ctrl
    import cgaplt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.command)
                    CMD_PLOT:
                    begin
                        state_next = ST_PIX_READ;
                    end
                    CMD_FILL:
                    begin
                        state_next = status.fill_empty ? ST_DONE : ST_PIX_READ;
                    end
                    CMD_SPRITE:
                    begin
                        if (status.sprite_reject)
                        begin
                            ctrl.clip_set = 1'b1;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            ctrl.div_start = 1'b1;
                            state_next     = ST_DIV_WAIT;
                        end
                    end
                    CMD_READ:
                    begin
                        state_next = ST_ADDR_READ;
                    end
                endcase
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    ctrl.sprite_base = 1'b1;
                    state_next       = ST_PIX_READ;
                end
            end
            ST_PIX_READ:
            begin
                if (status.on_screen)
                begin
                    ctrl.pixel_read = 1'b1;
                    state_next      = ST_PIX_WRITE;
                end
                else
                begin
                    ctrl.pixel_skip = 1'b1;
                    if (status.pixel_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PIX_WRITE:
            begin
                ctrl.pixel_write = 1'b1;
                state_next       = status.pixel_last ? ST_DONE : ST_PIX_READ;
            end
            ST_ADDR_READ:
            begin
                ctrl.addr_read = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.result_load = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ hw/rtl/cgaplt_datapath.sv @@
module cgaplt_datapath
    import cgaplt_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  request_t   req_payload,
    input  ctrl_cmd_t  ctrl,
    output dp_status_t status,
    input  logic       res_ready,
    output logic       res_valid,
    output result_t    res_payload
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);

    logic [7:0]        frame_mem [FRAME_BYTES];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;

    request_t   req_reg;
    logic [9:0] base_x_reg;
    logic [8:0] base_y_reg;
    logic [8:0] i_reg;
    logic [7:0] j_reg;
    logic       clip_reg;
    logic       out_valid_reg;
    result_t    res_reg;

    logic             div_done;
    logic [IDX_W-1:0] div_quo;
    logic [BPR_W-1:0] div_rem;

    logic [9:0]            px;
    logic [8:0]            py;
    logic [12:0]           line_off;
    logic [PIX_ADDR_W-1:0] pix_addr;
    logic [1:0]            pix_color;
    logic [7:0]            merged;
    logic [14:0]           frame_span;
    logic                  row_end;
    logic                  pixel_last;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [7:0]            wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  out_free;

    cgaplt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (req_reg.byte_index),
        .divisor   (req_reg.bytes_per_row),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // current pixel and its byte address in the interlaced layout
    always_comb
    begin
        px       = base_x_reg + {1'b0, i_reg};
        py       = base_y_reg + {1'b0, j_reg};
        line_off = 13'(py[7:1]) * 13'(LINE_BYTES);
        pix_addr = {1'b0, line_off} + {7'b0, px[8:2]} + (py[0] ? ODD_BANK : '0);
    end

    always_comb
    begin
        if (req_reg.command == CMD_SPRITE)
        begin
            unique case (i_reg[1:0])
                2'd0: pix_color = req_reg.pixel_byte[7:6];
                2'd1: pix_color = req_reg.pixel_byte[5:4];
                2'd2: pix_color = req_reg.pixel_byte[3:2];
                2'd3: pix_color = req_reg.pixel_byte[1:0];
            endcase
        end
        else
        begin
            pix_color = req_reg.color;
        end
    end

    // leftmost pixel sits in the top bit pair
    always_comb
    begin
        unique case (px[1:0])
            2'd0: merged = {pix_color, rd_data_reg[5:0]};
            2'd1: merged = {rd_data_reg[7:6], pix_color, rd_data_reg[3:0]};
            2'd2: merged = {rd_data_reg[7:4], pix_color, rd_data_reg[1:0]};
            2'd3: merged = {rd_data_reg[7:2], pix_color};
        endcase
    end

    always_comb
    begin
        row_end = j_reg == 8'(req_reg.height - 8'd1);
        unique case (req_reg.command)
            CMD_FILL:   pixel_last = row_end && (i_reg == 9'(req_reg.width - 9'd1));
            CMD_SPRITE: pixel_last = i_reg[1:0] == 2'd3;
            CMD_PLOT:   pixel_last = 1'b1;
            CMD_READ:   pixel_last = 1'b1;
        endcase
    end

    assign frame_span = 15'(req_reg.height) * 15'(req_reg.bytes_per_row);
    assign out_free   = !out_valid_reg || res_ready;

    always_comb
    begin
        status.command       = req_reg.command;
        status.clear_last    = clear_cnt_reg == ADDR_W'(FRAME_BYTES - 1);
        status.fill_empty    = (req_reg.width == '0) || (req_reg.height == '0);
        status.sprite_reject = (req_reg.x >= 9'(SCREEN_W)) || (req_reg.y >= 8'(SCREEN_H))
                               || (req_reg.bytes_per_row == '0)
                               || ({3'b0, req_reg.byte_index} >= frame_span);
        status.div_done      = div_done;
        status.on_screen     = (px < 10'(SCREEN_W)) && (py < 9'(SCREEN_H));
        status.pixel_last    = pixel_last;
        status.out_free      = out_free;
    end

    // single write port shared by the clear sweep and pixel writes
    always_comb
    begin
        wr_en   = ctrl.clear_write || ctrl.pixel_write;
        wr_addr = ctrl.clear_write ? clear_cnt_reg : ADDR_W'(pix_addr);
        wr_data = ctrl.clear_write ? 8'd0 : merged;
        rd_en   = ctrl.pixel_read || ctrl.addr_read;
        rd_addr = ctrl.addr_read ? ADDR_W'(req_reg.read_address) : ADDR_W'(pix_addr);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (ctrl.clear_write)
        begin
            clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg    <= req_payload;
            base_x_reg <= {1'b0, req_payload.x};
            base_y_reg <= {1'b0, req_payload.y};
        end
        else if (ctrl.sprite_base)
        begin
            base_x_reg <= {1'b0, req_reg.x} + {1'b0, div_rem, 2'b00};
            base_y_reg <= {1'b0, req_reg.y} + {1'b0, div_quo[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            clip_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            clip_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.pixel_skip || ctrl.clip_set)
            begin
                clip_reg <= 1'b1;
            end
            // fills walk down each column, sprites and plots walk across
            if (ctrl.pixel_skip || ctrl.pixel_write)
            begin
                if (req_reg.command == CMD_FILL && !row_end)
                begin
                    j_reg <= j_reg + 8'd1;
                end
                else
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.result_load)
        begin
            res_reg.read_data <= (req_reg.command == CMD_READ) ? rd_data_reg : 8'd0;
            res_reg.clipped   <= clip_reg;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_payload = res_reg;

endmodule

@@ hw/rtl/cga_2bpp_pixel_plotter.sv @@
// Draw engine over a 320x200 four-color interlaced framebuffer held in an on-chip
// single-port-write memory. After reset the block sweeps the framebuffer to zero, one
// byte a cycle, with request ready low. Each command then takes its own time, set by
// the read-modify-write loop on the framebuffer (one read and one write for each
// on-screen pixel, none for an off-screen one) and by a bit-serial divider: a read
// fetches one byte, a plot draws one pixel, a sprite byte runs 12 divide steps and then
// four pixels, and a fill visits each pixel of its rectangle column by column. A finished
// result waits in an output register, so the next request is taken while it is unread.
module cga_2bpp_pixel_plotter
    import cgaplt_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cgaplt_stream_if.sink   request,
    cgaplt_stream_if.source result
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;
    logic       in_ready;

    assign request.ready = in_ready;

    cgaplt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .ctrl     (ctrl_cmd)
    );

    cgaplt_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_payload (request.payload),
        .ctrl        (ctrl_cmd),
        .status      (dp_status),
        .res_ready   (result.ready),
        .res_valid   (result.valid),
        .res_payload (result.payload)
    );

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request taken while a command is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.pixel_write |-> dp_status.on_screen)
        else $error("framebuffer write for an off-screen pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.div_start |-> (dp_status.command == CMD_SPRITE))
        else $error("divider started for a command other than sprite");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.result_load |-> (!result.valid || result.ready))
        else $error("result overwritten before its transfer");

endmodule
